FILE: design/digit_string_stepper_defines.svh
// Assertion macros used by the top-level design file
`ifndef DIGIT_STRING_STEPPER_DEFINES_SVH
`define DIGIT_STRING_STEPPER_DEFINES_SVH

// same-cycle implication
`define DSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dss assertion failed");

// next-cycle implication
`define DSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dss assertion failed");

`endif

FILE: design/dss_pkg.sv
package dss_pkg;

	localparam int CODE_W = 16;
	localparam int PEND_W = 5;
	localparam int STEP_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX_HEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_OTHER = 2'd2;

	localparam logic signed [STEP_W-1:0] STEP_RESET = 6'sd1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;

	localparam logic [PEND_W-1:0] PEND_MAX = 5'd16;

	typedef struct packed {
		logic signed [STEP_W-1:0] step;
		logic                     radix_hex;
		logic                     skip_other;
	} cfg_t;

	// running per-string state
	typedef struct packed {
		logic [PEND_W-1:0] pend;
		logic              at_start;
		logic              seen_invalid;
	} run_t;

endpackage

FILE: design/dss_cfg.sv
module dss_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [dss_pkg::CFG_IDX_W-1:0] index,
	input  logic [dss_pkg::STEP_W-1:0]    data,
	output dss_pkg::cfg_t                 cfg
);
	import dss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step       <= STEP_RESET;
			cfg_q.radix_hex  <= 1'b1;
			cfg_q.skip_other <= 1'b0;
		end else if (we) begin
			unique case (index)
				CFG_STEP:       cfg_q.step       <= $signed(data);
				CFG_RADIX_HEX:  cfg_q.radix_hex  <= data[0];
				CFG_SKIP_OTHER: cfg_q.skip_other <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/dss_digit.sv
module dss_digit (
	input  dss_pkg::cfg_t               cfg,
	input  logic [dss_pkg::CODE_W-1:0]  code_in,
	input  logic                        last,
	input  dss_pkg::run_t               run_in,
	output logic [dss_pkg::CODE_W-1:0]  code_out,
	output logic                        acc,
	output dss_pkg::run_t               run_out
);
	import dss_pkg::*;

	logic [7:0]              lo;
	logic                    hi_zero, is_dec, is_up, is_low, is_digit;
	logic [3:0]              dval;
	logic                    neg, step_ok;
	logic signed [STEP_W:0]  limit;
	logic [STEP_W-1:0]       mag;
	logic [PEND_W-1:0]       pend_eff, pend_nx;
	logic                    seen_eff, seen_nx;
	logic signed [6:0]       s_raw, radix, s_fix;
	logic [7:0]              dig_lo;
	logic [CODE_W-1:0]       dig_code;

	always_comb begin
		lo      = code_in[7:0];
		hi_zero = (code_in[CODE_W-1:8] == '0);
		is_dec  = hi_zero && (lo >= CH_ZERO) && (lo <= CH_NINE);
		is_up   = cfg.radix_hex && hi_zero && (lo >= CH_UP_A) && (lo <= CH_UP_F);
		is_low  = cfg.radix_hex && hi_zero && (lo >= CH_LOW_A) && (lo <= CH_LOW_F);
		is_digit = is_dec || is_up || is_low;

		priority if (is_dec) dval = 4'(lo - CH_ZERO);
		else if (is_up)      dval = 4'(lo - CH_UP_A + 8'd10);
		else if (is_low)     dval = 4'(lo - CH_LOW_A + 8'd10);
		else                 dval = 4'd0;

		neg     = cfg.step[STEP_W-1];
		limit   = cfg.radix_hex ? 7'sd16 : 7'sd10;
		step_ok = (cfg.step != '0) && ($signed({cfg.step[STEP_W-1], cfg.step}) <= limit)
			&& ($signed({cfg.step[STEP_W-1], cfg.step}) >= -limit);
		mag     = neg ? STEP_W'(-cfg.step) : STEP_W'(cfg.step);

		pend_eff = run_in.at_start ? (step_ok ? mag[PEND_W-1:0] : '0) : run_in.pend;
		seen_eff = run_in.at_start ? 1'b0 : run_in.seen_invalid;

		radix = cfg.radix_hex ? 7'sd16 : 7'sd10;
		s_raw = neg ? $signed({3'b000, dval}) - $signed({2'b00, pend_eff})
			: $signed({3'b000, dval}) + $signed({2'b00, pend_eff});

		if (s_raw >= radix) begin
			s_fix   = s_raw - radix;
			pend_nx = 5'd1;
		end else if (s_raw < 0) begin
			s_fix   = s_raw + radix;
			pend_nx = 5'd1;
		end else begin
			s_fix   = s_raw;
			pend_nx = '0;
		end
		// radix dropped mid-string can leave a negative value below '0'
		dig_lo   = (s_fix < 7'sd10) ? CH_ZERO + {s_fix[6], s_fix}
			: CH_UP_A + {s_fix[6], s_fix} - 8'd10;
		dig_code = CODE_W'(dig_lo);

		code_out = code_in;
		seen_nx  = seen_eff;
		if (!is_digit) begin
			pend_nx = pend_eff;
			if (!cfg.skip_other) seen_nx = 1'b1;
		end else if (pend_eff == '0) begin
			pend_nx = '0;
		end else begin
			code_out = dig_code;
		end

		acc = last && step_ok && !seen_nx;
		if (last) begin
			run_out.pend         = '0;
			run_out.seen_invalid = 1'b0;
			run_out.at_start     = 1'b1;
		end else begin
			run_out.pend         = pend_nx;
			run_out.seen_invalid = seen_nx;
			run_out.at_start     = 1'b0;
		end
	end

endmodule

FILE: design/digit_string_stepper.sv
// Requests enter s1, are stepped, and are registered in s2 for the m_ side.
// Throughput: one character per cycle unless m_tready stalls; the only loop
// is the pending-carry register feeding the next character's digit adder.
// Reset: arst_n asynchronous active low; clears both valid stages, the carry
// state, and loads step=1, radix_hex=1, skip_other=0.
`include "digit_string_stepper_defines.svh"

module digit_string_stepper #(
	parameter int CHAR_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dss_pkg::STEP_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // [15:0] char_code
	input  logic                          s_tlast,  // leftmost
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // [15:0] out_code
	output logic                          m_tlast,  // string_end
	output logic                          m_tuser   // [0] accepted
);
	import dss_pkg::*;

	cfg_t              cfg;
	run_t              run_q, run_nx;
	logic              valid_s1, last_s1;
	logic [CODE_W-1:0] code_s1;
	logic              valid_s2, last_s2, acc_s2;
	logic [CODE_W-1:0] code_s2;
	logic [CODE_W-1:0] code_nx, code_masked;
	logic              acc_nx, adv;

	dss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		code_masked = '0;
		code_masked[CHAR_BITS-1:0] = s_tdata[CHAR_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= code_masked;
			last_s1 <= s_tlast;
		end
	end

	dss_digit u_digit (
		.cfg      (cfg),
		.code_in  (code_s1),
		.last     (last_s1),
		.run_in   (run_q),
		.code_out (code_nx),
		.acc      (acc_nx),
		.run_out  (run_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q.pend         <= '0;
			run_q.at_start     <= 1'b1;
			run_q.seen_invalid <= 1'b0;
			valid_s2           <= 1'b0;
		end else begin
			if (adv) run_q <= run_nx;
			if (adv) valid_s2 <= 1'b1;
			else if (m_tready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s2 <= code_nx;
			last_s2 <= last_s1;
			acc_s2  <= acc_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = code_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = acc_s2;

	`DSS_ASSERT_NOW(a_acc_on_end, m_tvalid && m_tuser, m_tlast)
	`DSS_ASSERT_NEXT(a_end_resets_run, adv && last_s1,
		run_q.at_start && (run_q.pend == '0) && !run_q.seen_invalid)
	`DSS_ASSERT_NOW(a_pend_bounded, 1'b1, run_q.pend <= PEND_MAX)
	`DSS_ASSERT_NOW(a_start_no_pend, run_q.at_start, (run_q.pend == '0) && !run_q.seen_invalid)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import dss_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_CHARS = 450;
	localparam int PLAN_LEN = 30;

	typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [15:0] code;
		logic        last;
		logic        acc;
	} char_res_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [15:0]              code;
		logic                     last;
		logic signed [STEP_W-1:0] st;
		logic                     hex;
		logic                     skip;
		logic                     typed;
		logic [15:0]              want;
		logic                     want_acc;
	} plan_row_t;

	// kind, code, last, step, hex, skip, typed, want, want_acc
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_CHAR, 16'h0030, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0031, 1'b1},
		'{ROW_CHAR, 16'h0066, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0030, 1'b1},
		'{ROW_CHAR, 16'h0078, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0078, 1'b0},
		'{ROW_CHAR, 16'h0139, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0139, 1'b0},
		'{ROW_CHAR, 16'h0039, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0041, 1'b0},
		'{ROW_CHAR, 16'hFFFF, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, -6'sd16, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0035, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h002D, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0030, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0033, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0033, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'sd11, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0033, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0033, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'sd10, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0037, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0039, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0061, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'sd31, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0000, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'b100000, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0031, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h0031, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'sd16, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0046, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		// reconfigured mid-string: carry kept, direction flips
		'{ROW_CFG,  16'h0000, 1'b0, -6'sd3, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0032, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h007A, 1'b0, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h0038, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  16'h0000, 1'b0, 6'sd1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CHAR, 16'h00FF, 1'b1, 6'sd0, 1'b0, 1'b0, 1'b1, 16'h00FF, 1'b0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [STEP_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;

	// predictor state and register copies
	logic signed [STEP_W-1:0] mdl_step;
	logic                     mdl_hex;
	logic                     mdl_skip;
	logic [PEND_W-1:0]        mdl_pend;
	logic                     mdl_at_start;
	logic                     mdl_bad;

	char_res_t stepped_chars [$];

	int errors = 0;
	int cycles = 0;
	int chars_sent;
	int chars_seen = 0;
	int strings_seen = 0;
	int strings_accepted = 0;
	int cfg_writes;
	int burst_left;
	int rx_mode = 0;
	int rx_cnt = 0;

	digit_string_stepper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic char_res_t step_char(input logic [15:0] c, input logic last);
		int st;
		int lim;
		int d;
		int s;
		logic ok;
		char_res_t r;
		st = int'(mdl_step);
		lim = mdl_hex ? 16 : 10;
		ok = (st != 0) && (st <= lim) && (st >= -lim);
		if (mdl_at_start) begin
			mdl_pend = ok ? PEND_W'(st < 0 ? -st : st) : '0;
			mdl_bad = 1'b0;
		end
		d = -1;
		if (c >= 16'(CH_ZERO) && c <= 16'(CH_NINE)) begin
			d = int'(c) - int'(CH_ZERO);
		end else if (mdl_hex && c >= 16'(CH_UP_A) && c <= 16'(CH_UP_F)) begin
			d = int'(c) - int'(CH_UP_A) + 10;
		end else if (mdl_hex && c >= 16'(CH_LOW_A) && c <= 16'(CH_LOW_F)) begin
			d = int'(c) - int'(CH_LOW_A) + 10;
		end
		r.code = c;
		if (d < 0) begin
			if (!mdl_skip)
				mdl_bad = 1'b1;
		end else if (mdl_pend != '0) begin
			s = (st < 0) ? d - int'(mdl_pend) : d + int'(mdl_pend);
			mdl_pend = '0;
			if (s >= lim) begin
				s -= lim;
				mdl_pend = PEND_W'(1);
			end else if (s < 0) begin
				s += lim;
				mdl_pend = PEND_W'(1);
			end
			r.code = (s < 10) ? 16'(int'(CH_ZERO) + s) : 16'(int'(CH_UP_A) + s - 10);
		end
		r.last = last;
		r.acc = last && ok && !mdl_bad;
		if (last) begin
			mdl_pend = '0;
			mdl_bad = 1'b0;
			mdl_at_start = 1'b1;
		end else begin
			mdl_at_start = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_char();
		int pick;
		int lim;
		int v;
		lim = mdl_hex ? 16 : 10;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			v = $urandom_range(0, lim - 1);
			if (v < 10)
				return 16'(int'(CH_ZERO) + v);
			return 16'(int'($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + v - 10);
		end
		if (pick < 65) begin
			if (!mdl_hex)
				return 16'(CH_NINE);
			return 16'($urandom_range(0, 1) ? CH_UP_F : CH_LOW_F);
		end
		if (pick < 75)
			return 16'(CH_ZERO);
		if (pick < 88)
			return 16'($urandom_range(0, 255));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_char(input logic [15:0] c, input logic last, input logic typed,
			input char_res_t want);
		char_res_t r;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		r = step_char(c, last);
		stepped_chars.push_back(typed ? want : r);
		chars_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		while (stepped_chars.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_cfg(input logic signed [STEP_W-1:0] st, input logic hex,
			input logic skip);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STEP;
		cfg_data <= st;
		@(posedge clk);
		cfg_index <= CFG_RADIX_HEX;
		cfg_data <= STEP_W'(hex);
		@(posedge clk);
		cfg_index <= CFG_SKIP_OTHER;
		cfg_data <= STEP_W'(skip);
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_step = st;
		mdl_hex = hex;
		mdl_skip = skip;
		cfg_writes += 3;
	endtask

	task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
	endtask

	// receiver stall pattern: rx_cnt sets when a new random rx_mode is drawn
	always @(posedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if (rx_cnt % 40 == 39)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= (rx_cnt % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		char_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (stepped_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h last %b accepted %b",
					$time, m_tdata, m_tlast, m_tuser);
			end else begin
				exp_r = stepped_chars.pop_front();
				chars_seen++;
				if (m_tdata !== exp_r.code)
					flag("out_code", exp_r.code, m_tdata);
				if (m_tlast !== exp_r.last)
					flag("string_end", 16'(exp_r.last), 16'(m_tlast));
				if (m_tuser !== exp_r.acc)
					flag("accepted", 16'(exp_r.acc), 16'(m_tuser));
				if (exp_r.last) begin
					strings_seen++;
					if (exp_r.acc)
						strings_accepted++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				stepped_chars.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int lim;
		int mag;
		int pick;
		int len;
		logic signed [STEP_W-1:0] st;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		chars_sent = 0;
		cfg_writes = 0;
		burst_left = 0;
		mdl_step = STEP_RESET;
		mdl_hex = 1'b1;
		mdl_skip = 1'b0;
		mdl_pend = '0;
		mdl_at_start = 1'b1;
		mdl_bad = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				drain(4);
				load_cfg(PLAN[i].st, PLAN[i].hex, PLAN[i].skip);
			end else begin
				send_char(PLAN[i].code, PLAN[i].last, PLAN[i].typed,
					'{PLAN[i].want, PLAN[i].last, PLAN[i].want_acc});
			end
		end

		while (chars_sent < PLAN_LEN + RANDOM_CHARS) begin
			drain(4);
			pick = $urandom_range(0, 9);
			lim = $urandom_range(0, 1) ? 16 : 10;
			if (pick < 7) begin
				mag = $urandom_range(1, lim);
				st = STEP_W'($urandom_range(0, 1) ? -mag : mag);
			end else if (pick == 7) begin
				st = STEP_W'($urandom_range(0, 1) ? -lim : lim);
			end else begin
				st = STEP_W'($urandom_range(0, 63));
			end
			load_cfg(st, lim == 16, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(4, 12)) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
					: $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_char(rand_char(), k == len - 1, 1'b0, '0);
			end
		end

		drain(10);
		$display("checked %0d characters in %0d strings, %0d strings stepped", chars_seen,
			strings_seen, strings_accepted);
		$display("%0d register writes, %0d mismatches", cfg_writes, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
